// ----- rtl/core/rfr_pkg.sv -----
// Package for the RTCM fragment reassembler: shared types, constants and byte-mask helpers.
// Used by every module under rtl/core but rfr_checker; depends on nothing.
`default_nettype none

package rfr_pkg;

    // Default sizing, handed to the top-level parameters
    localparam int DEF_SEQUENCE_SLOTS    = 32;
    localparam int DEF_FRAGMENTS_PER_SEQ = 4;
    localparam int DEF_FRAGMENT_BYTES    = 180;
    localparam int DEF_CHUNK_BYTES       = 300;

    // Fixed widths set by the message flag layout
    localparam int MAX_FRAGS   = 4;   // fragment index field is two bits
    localparam int SEQ_W       = 5;   // sequence field is five bits
    localparam int SEQ_COUNT   = 32;
    localparam int LEN_W       = 11;  // holds joined totals and chunk sizes
    localparam int ACC_BYTES   = 32;  // back-end byte aligner capacity
    localparam int RESULT_BYTES = 16;
    localparam int QUEUE_DEPTH = 2;
    localparam int TAG_COUNT   = QUEUE_DEPTH + 1;

    // One delivery job handed from the front end to the back end
    typedef struct packed {
        logic                          pt;     // passthrough buffer, not a fragment slot
        logic [SEQ_W-1:0]              slot;
        logic [1:0]                    last;   // last fragment index to join
        logic [MAX_FRAGS-1:0][7:0]     lens;   // per-fragment byte lengths
        logic [LEN_W-1:0]              total;  // joined byte count
    } t_job;

    // Storage region that an in-flight job still reads
    typedef struct packed {
        logic             v;
        logic             pt;
        logic [SEQ_W-1:0] slot;
    } t_tag;

    // Keep the low n bytes of a 16-byte result
    function automatic logic [8*RESULT_BYTES-1:0] mask_result(input logic [4:0] n);
        logic [8*RESULT_BYTES-1:0] m;
        m = '0;
        for (int b = 0; b < RESULT_BYTES; b++) begin
            if (5'(b) < n) begin
                m[8*b +: 8] = 8'hFF;
            end
        end
        return m;
    endfunction

    // Keep the low n bytes of a 64-bit word
    function automatic logic [63:0] mask_word(input logic [3:0] n);
        logic [63:0] m;
        m = '0;
        for (int b = 0; b < 8; b++) begin
            if (4'(b) < n) begin
                m[8*b +: 8] = 8'hFF;
            end
        end
        return m;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/rfr_queue.sv -----
// Two-entry job queue between the reassembler front end and back end.
// Depends on rfr_pkg for the job and tag types.
`default_nettype none

module rfr_queue
    import rfr_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_job  i_job,
    input  wire logic  i_pop,
    output t_job       o_job,
    output logic       o_empty,
    output logic       o_full,
    output t_tag [QUEUE_DEPTH-1:0] o_tags
);

    t_job       r_mem [QUEUE_DEPTH];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       push_go;
    logic       pop_go;

    assign o_empty = (r_cnt == 2'd0);
    assign o_full  = (r_cnt == 2'(QUEUE_DEPTH));
    assign push_go = i_push && !o_full;
    assign pop_go  = i_pop && !o_empty;
    assign o_job   = r_mem[r_rp];

    // Report which stored jobs are live, for the front-end hazard check
    always_comb begin
        for (int k = 0; k < QUEUE_DEPTH; k++) begin
            o_tags[k].v    = o_full || (!o_empty && (r_rp == 1'(k)));
            o_tags[k].pt   = r_mem[k].pt;
            o_tags[k].slot = r_mem[k].slot;
        end
    end

    // Store pushed jobs
    always_ff @(posedge i_clk) begin
        if (push_go) begin
            r_mem[r_wp] <= i_job;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push_go) begin
                r_wp <= ~r_wp;
            end
            if (pop_go) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(push_go) - 2'(pop_go);
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/rfr_front.sv -----
// Reassembler front end: accepts words, writes the word store, tracks fragment slots
// and pushes delivery jobs. Depends on rfr_pkg.
`default_nettype none

module rfr_front
    import rfr_pkg::*;
#(
    parameter int SEQUENCE_SLOTS    = DEF_SEQUENCE_SLOTS,
    parameter int FRAGMENTS_PER_SEQ = DEF_FRAGMENTS_PER_SEQ,
    parameter int FRAGMENT_BYTES    = DEF_FRAGMENT_BYTES,
    parameter int AW                = 12
)
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_msg_flags,
    input  wire logic [7:0]  i_fragment_length,
    input  wire logic [63:0] i_data_word,
    input  wire logic        i_last_word,
    output logic             o_wr_en,
    output logic [AW-1:0]    o_wr_addr,
    output logic [63:0]      o_wr_data,
    output logic             o_push,
    output t_job             o_job,
    input  wire logic        i_q_full,
    input  wire t_tag [TAG_COUNT-1:0] i_tags
);

    localparam int FW      = (FRAGMENT_BYTES + 7) / 8;
    localparam int SLW     = (SEQUENCE_SLOTS > 1) ? $clog2(SEQUENCE_SLOTS) : 1;
    localparam int PT_BASE = SEQUENCE_SLOTS * FRAGMENTS_PER_SEQ * FW;

    logic [MAX_FRAGS-1:0][7:0] r_lens [SEQUENCE_SLOTS];
    logic [MAX_FRAGS-1:0]      r_mask [SEQUENCE_SLOTS];
    logic [1:0]                r_li   [SEQUENCE_SLOTS];
    logic                      r_kn   [SEQUENCE_SLOTS];
    logic [4:0]                r_pos;

    logic [SLW-1:0]            mod_tab [SEQ_COUNT];
    logic                      frag;
    logic [1:0]                idx;
    logic [SLW-1:0]            slot;
    logic                      idx_ok;
    logic                      pos_ok;
    logic [7:0]                flen;
    logic                      hazard;
    logic                      accept;
    logic [MAX_FRAGS-1:0][7:0] row;
    logic [MAX_FRAGS-1:0]      mask_n;
    logic [MAX_FRAGS-1:0]      expect_m;
    logic [1:0]                li_n;
    logic                      kn_n;
    logic                      complete;
    logic [LEN_W-1:0]          sum;
    logic                      upd;

    // Sequence number modulo the slot count, as a constant lookup
    for (genvar v = 0; v < SEQ_COUNT; v++) begin : g_mod
        assign mod_tab[v] = SLW'(v % SEQUENCE_SLOTS);
    end

    // Classify the word
    assign frag   = i_msg_flags[0];
    assign idx    = i_msg_flags[2:1];
    assign slot   = mod_tab[i_msg_flags[7:3]];
    assign idx_ok = ({1'b0, idx} < 3'(FRAGMENTS_PER_SEQ));
    assign pos_ok = ({1'b0, r_pos} < 6'(FW));
    assign flen   = (i_fragment_length > 8'(FRAGMENT_BYTES)) ? 8'(FRAGMENT_BYTES)
                                                             : i_fragment_length;

    // Hold words that would overwrite storage a pending job still reads
    always_comb begin
        hazard = 1'b0;
        for (int k = 0; k < TAG_COUNT; k++) begin
            if (i_tags[k].v && ((i_tags[k].pt && !frag) ||
                (!i_tags[k].pt && frag && (i_tags[k].slot == SEQ_W'(slot))))) begin
                hazard = 1'b1;
            end
        end
    end

    assign o_ready = !(hazard || (i_last_word && i_q_full));
    assign accept  = i_valid && o_ready;

    // Word store write
    assign o_wr_en   = accept && pos_ok && (!frag || idx_ok);
    assign o_wr_data = i_data_word;
    assign o_wr_addr = frag ? AW'((int'(slot) * FRAGMENTS_PER_SEQ + int'(idx)) * FW
                                 + int'(r_pos))
                            : AW'(PT_BASE + int'(r_pos));

    // Slot bookkeeping with this fragment folded in
    always_comb begin
        row       = r_lens[slot];
        row[idx]  = flen;
        mask_n    = r_mask[slot] | (MAX_FRAGS'(1) << idx);
        li_n      = (flen < 8'(FRAGMENT_BYTES)) ? idx : r_li[slot];
        kn_n      = (flen < 8'(FRAGMENT_BYTES)) || r_kn[slot];
        sum       = '0;
        for (int i = 0; i < MAX_FRAGS; i++) begin
            expect_m[i] = (3'(i) <= {1'b0, li_n});
            if (expect_m[i]) begin
                sum = sum + LEN_W'(row[i]);
            end
        end
        complete = kn_n && ((mask_n & expect_m) == expect_m);
    end

    assign upd    = accept && i_last_word && frag && idx_ok;
    assign o_push = accept && i_last_word && (!frag || (idx_ok && complete));

    // Build the job
    always_comb begin
        o_job.slot = SEQ_W'(slot);
        if (!frag) begin
            o_job.pt      = 1'b1;
            o_job.last    = 2'd0;
            o_job.lens    = '0;
            o_job.lens[0] = flen;
            o_job.total   = LEN_W'(flen);
        end else begin
            o_job.pt      = 1'b0;
            o_job.last    = li_n;
            o_job.lens    = row;
            o_job.total   = sum;
        end
    end

    // Record fragment lengths
    always_ff @(posedge i_clk) begin
        if (upd) begin
            r_lens[slot][idx] <= flen;
        end
    end

    // Update slot status, clear on completion
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < SEQUENCE_SLOTS; s++) begin
                r_mask[s] <= '0;
                r_li[s]   <= 2'd0;
                r_kn[s]   <= 1'b0;
            end
        end else if (upd) begin
            if (complete) begin
                r_mask[slot] <= '0;
                r_li[slot]   <= 2'd0;
                r_kn[slot]   <= 1'b0;
            end else begin
                r_mask[slot] <= mask_n;
                r_li[slot]   <= li_n;
                r_kn[slot]   <= kn_n;
            end
        end
    end

    // Track word position within the message
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= 5'd0;
        end else if (accept) begin
            if (i_last_word) begin
                r_pos <= 5'd0;
            end else if (r_pos != 5'd31) begin
                r_pos <= r_pos + 5'd1;
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/rfr_back.sv -----
// Reassembler back end: holds the word store, reads a job's words, realigns bytes
// and emits 16-byte results in chunks. Depends on rfr_pkg.
`default_nettype none

module rfr_back
    import rfr_pkg::*;
#(
    parameter int SEQUENCE_SLOTS    = DEF_SEQUENCE_SLOTS,
    parameter int FRAGMENTS_PER_SEQ = DEF_FRAGMENTS_PER_SEQ,
    parameter int FRAGMENT_BYTES    = DEF_FRAGMENT_BYTES,
    parameter int CHUNK_BYTES       = DEF_CHUNK_BYTES,
    parameter int AW                = 12
)
(
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_wr_en,
    input  wire logic [AW-1:0] i_wr_addr,
    input  wire logic [63:0]   i_wr_data,
    input  wire logic          i_q_empty,
    input  wire t_job          i_job,
    output logic               o_pop,
    output t_tag               o_tag,
    output logic               o_valid,
    input  wire logic          i_ready,
    output logic [63:0]        o_data_low,
    output logic [63:0]        o_data_high,
    output logic [4:0]         o_byte_count,
    output logic [8:0]         o_chunk_length,
    output logic               o_chunk_first,
    output logic               o_chunk_last,
    output logic               o_multi_chunk,
    output logic               o_last_result
);

    localparam int FW      = (FRAGMENT_BYTES + 7) / 8;
    localparam int PT_BASE = SEQUENCE_SLOTS * FRAGMENTS_PER_SEQ * FW;
    localparam int DEPTH   = PT_BASE + FW;
    localparam int ACC_W   = 8 * ACC_BYTES;
    localparam int CNT_W   = $clog2(ACC_BYTES + 1);

    logic [63:0]        r_mem [DEPTH];
    logic [63:0]        r_rd_data;
    logic               r_rd_v;
    logic [3:0]         r_rd_nb;

    logic               r_busy, n_busy;
    t_job               r_job,  n_job;
    logic [1:0]         r_fi,   n_fi;
    logic [7:0]         r_frem, n_frem;
    logic [AW-1:0]      r_addr, n_addr;
    logic [ACC_W-1:0]   r_acc,  n_acc;
    logic [CNT_W-1:0]   r_cnt,  n_cnt;
    logic [LEN_W-1:0]   r_tot,  n_tot;
    logic [LEN_W-1:0]   r_ckr,  n_ckr;
    logic [LEN_W-1:0]   r_ckl,  n_ckl;
    logic               r_first, n_first;
    logic               r_multi, n_multi;

    logic               r_out_v;
    logic [127:0]       r_out_data;
    logic [4:0]         r_out_cnt;
    logic [8:0]         r_out_ckl;
    logic               r_out_first, r_out_last, r_out_multi, r_out_lr;

    logic               load, rd_go, adv, emit, done, out_free;
    logic [3:0]         nb;
    logic [4:0]         e;
    logic [LEN_W-1:0]   tot_after;

    // Word address of fragment fi of a job
    function automatic logic [AW-1:0] base_of(input t_job j, input logic [1:0] fi);
        if (j.pt) begin
            return AW'(PT_BASE);
        end
        return AW'((int'(j.slot) * FRAGMENTS_PER_SEQ + int'(fi)) * FW);
    endfunction

    function automatic logic [LEN_W-1:0] chunk_of(input logic [LEN_W-1:0] t);
        return (t > LEN_W'(CHUNK_BYTES)) ? LEN_W'(CHUNK_BYTES) : t;
    endfunction

    assign out_free = !r_out_v || i_ready;
    assign load     = !r_busy && !i_q_empty;
    assign o_pop    = load;
    assign nb       = (r_frem >= 8'd8) ? 4'd8 : r_frem[3:0];
    assign rd_go    = r_busy && (r_frem != 8'd0) && (r_cnt <= CNT_W'(RESULT_BYTES));
    assign adv      = r_busy && (r_frem == 8'd0) && !r_job.pt && (r_fi < r_job.last);
    assign e        = (r_ckr >= LEN_W'(RESULT_BYTES)) ? 5'(RESULT_BYTES) : r_ckr[4:0];
    assign emit     = r_busy && (r_tot != '0) && (r_cnt >= CNT_W'(e)) && out_free;
    assign done     = r_busy && (r_tot == '0);
    assign tot_after = r_tot - LEN_W'(e);

    assign o_tag.v    = r_busy;
    assign o_tag.pt   = r_job.pt;
    assign o_tag.slot = r_job.slot;

    // Word store: front end writes, back end reads
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (rd_go) begin
            r_rd_data <= r_mem[r_addr];
        end
    end

    // Next state of the job sequencer and byte aligner
    always_comb begin
        n_busy  = r_busy;
        n_job   = r_job;
        n_fi    = r_fi;
        n_frem  = r_frem;
        n_addr  = r_addr;
        n_acc   = r_acc;
        n_cnt   = r_cnt;
        n_tot   = r_tot;
        n_ckr   = r_ckr;
        n_ckl   = r_ckl;
        n_first = r_first;
        n_multi = r_multi;

        if (load) begin
            n_busy  = 1'b1;
            n_job   = i_job;
            n_fi    = 2'd0;
            n_frem  = i_job.lens[0];
            n_addr  = base_of(i_job, 2'd0);
            n_tot   = i_job.total;
            n_ckl   = chunk_of(i_job.total);
            n_ckr   = chunk_of(i_job.total);
            n_first = 1'b1;
            n_multi = (i_job.total > LEN_W'(CHUNK_BYTES));
        end else if (done) begin
            n_busy = 1'b0;
        end

        // Step through fragment words
        if (rd_go) begin
            n_frem = r_frem - 8'(nb);
            n_addr = r_addr + AW'(1);
        end else if (adv) begin
            n_fi   = r_fi + 2'd1;
            n_frem = r_job.lens[r_fi + 2'd1];
            n_addr = base_of(r_job, r_fi + 2'd1);
        end

        // Drop emitted bytes, then append the arriving word
        if (emit) begin
            n_acc = r_acc >> {e, 3'b000};
            n_cnt = r_cnt - CNT_W'(e);
            n_tot = tot_after;
            if (r_ckr == LEN_W'(e)) begin
                n_ckl   = chunk_of(tot_after);
                n_ckr   = chunk_of(tot_after);
                n_first = 1'b1;
            end else begin
                n_ckr   = r_ckr - LEN_W'(e);
                n_first = 1'b0;
            end
        end
        if (r_rd_v) begin
            n_acc = n_acc | (ACC_W'(r_rd_data & mask_word(r_rd_nb)) << {n_cnt, 3'b000});
            n_cnt = n_cnt + CNT_W'(r_rd_nb);
        end
    end

    // Job and aligner registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_rd_v <= 1'b0;
            r_frem <= 8'd0;
            r_acc  <= '0;
            r_cnt  <= '0;
            r_tot  <= '0;
        end else begin
            r_busy <= n_busy;
            r_rd_v <= rd_go;
            r_frem <= n_frem;
            r_acc  <= n_acc;
            r_cnt  <= n_cnt;
            r_tot  <= n_tot;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job   <= n_job;
        r_fi    <= n_fi;
        r_addr  <= n_addr;
        r_ckr   <= n_ckr;
        r_ckl   <= n_ckl;
        r_first <= n_first;
        r_multi <= n_multi;
        if (rd_go) begin
            r_rd_nb <= nb;
        end
    end

    // Output register: load on emit, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (emit) begin
            r_out_v <= 1'b1;
        end else if (i_ready) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_data  <= r_acc[127:0] & mask_result(e);
            r_out_cnt   <= e;
            r_out_ckl   <= r_ckl[8:0];
            r_out_first <= r_first;
            r_out_last  <= (r_ckr == LEN_W'(e));
            r_out_multi <= r_multi;
            r_out_lr    <= (r_tot == LEN_W'(e));
        end
    end

    assign o_valid        = r_out_v;
    assign o_data_low     = r_out_data[63:0];
    assign o_data_high    = r_out_data[127:64];
    assign o_byte_count   = r_out_cnt;
    assign o_chunk_length = r_out_ckl;
    assign o_chunk_first  = r_out_first;
    assign o_chunk_last   = r_out_last;
    assign o_multi_chunk  = r_out_multi;
    assign o_last_result  = r_out_lr;

endmodule

`default_nettype wire

// ----- rtl/core/rtcm_fragment_reassembler.sv -----
// RTCM fragment reassembler top level: front end, job queue and back end.
// Depends on rfr_pkg, rfr_front, rfr_queue and rfr_back.
//
// Usage:
//   Input channel (i_valid/o_ready) takes one 8-byte message word per transaction.
//   Unfragmented messages are replayed from a passthrough buffer; fragments are kept
//   per sequence slot and delivered joined once indexes 0..last are all present.
//   Output channel (o_valid/i_ready) gives 16-byte results grouped in chunks of at
//   most CHUNK_BYTES bytes.
//   Throughput: input words go at one per cycle while o_ready is high; the back end reads
//   one stored word per cycle from its single read port while its byte aligner has room,
//   so a delivery drains at about 8 bytes per cycle.
//   A delivery's first result passes from the job queue through the job registers, store
//   read and aligner to the output register, later if earlier deliveries still drain.
//   A word stalls (o_ready low) while it would overwrite storage that a pending
//   delivery still reads, or when it completes a message and the two-job queue is full.
//   Receiver stall: the output register holds its result; the back end pauses and
//   the front end keeps taking words until one of the stalls above.
//   Reset: synchronous, active low; clears slot status, queue and output valid.
//   The word store needs no clearing pass.
`default_nettype none

module rtcm_fragment_reassembler
    import rfr_pkg::*;
#(
    parameter int SEQUENCE_SLOTS    = DEF_SEQUENCE_SLOTS,
    parameter int FRAGMENTS_PER_SEQ = DEF_FRAGMENTS_PER_SEQ,
    parameter int FRAGMENT_BYTES    = DEF_FRAGMENT_BYTES,
    parameter int CHUNK_BYTES       = DEF_CHUNK_BYTES
)
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_msg_flags,
    input  wire logic [7:0]  i_fragment_length,
    input  wire logic [63:0] i_data_word,
    input  wire logic        i_last_word,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [63:0]      o_data_low,
    output logic [63:0]      o_data_high,
    output logic [4:0]       o_byte_count,
    output logic [8:0]       o_chunk_length,
    output logic             o_chunk_first,
    output logic             o_chunk_last,
    output logic             o_multi_chunk,
    output logic             o_last_result
);

    localparam int FW = (FRAGMENT_BYTES + 7) / 8;
    localparam int AW = $clog2(SEQUENCE_SLOTS * FRAGMENTS_PER_SEQ * FW + FW);

    logic                     wr_en;
    logic [AW-1:0]            wr_addr;
    logic [63:0]              wr_data;
    logic                     push;
    logic                     pop;
    logic                     q_empty;
    logic                     q_full;
    t_job                     job_in;
    t_job                     job_out;
    t_tag [QUEUE_DEPTH-1:0]   q_tags;
    t_tag                     back_tag;
    t_tag [TAG_COUNT-1:0]     tags;

    // Collect every job that still reads the store
    assign tags = {back_tag, q_tags};

    rfr_front #(
        .SEQUENCE_SLOTS    (SEQUENCE_SLOTS),
        .FRAGMENTS_PER_SEQ (FRAGMENTS_PER_SEQ),
        .FRAGMENT_BYTES    (FRAGMENT_BYTES),
        .AW                (AW)
    ) u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_msg_flags       (i_msg_flags),
        .i_fragment_length (i_fragment_length),
        .i_data_word       (i_data_word),
        .i_last_word       (i_last_word),
        .o_wr_en           (wr_en),
        .o_wr_addr         (wr_addr),
        .o_wr_data         (wr_data),
        .o_push            (push),
        .o_job             (job_in),
        .i_q_full          (q_full),
        .i_tags            (tags)
    );

    rfr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job_in),
        .i_pop   (pop),
        .o_job   (job_out),
        .o_empty (q_empty),
        .o_full  (q_full),
        .o_tags  (q_tags)
    );

    rfr_back #(
        .SEQUENCE_SLOTS    (SEQUENCE_SLOTS),
        .FRAGMENTS_PER_SEQ (FRAGMENTS_PER_SEQ),
        .FRAGMENT_BYTES    (FRAGMENT_BYTES),
        .CHUNK_BYTES       (CHUNK_BYTES),
        .AW                (AW)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_wr_en        (wr_en),
        .i_wr_addr      (wr_addr),
        .i_wr_data      (wr_data),
        .i_q_empty      (q_empty),
        .i_job          (job_out),
        .o_pop          (pop),
        .o_tag          (back_tag),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_data_low     (o_data_low),
        .o_data_high    (o_data_high),
        .o_byte_count   (o_byte_count),
        .o_chunk_length (o_chunk_length),
        .o_chunk_first  (o_chunk_first),
        .o_chunk_last   (o_chunk_last),
        .o_multi_chunk  (o_multi_chunk),
        .o_last_result  (o_last_result)
    );

endmodule

`default_nettype wire

// ----- rtl/core/rfr_checker.sv -----
// Port-level checks for the RTCM fragment reassembler, bound to the top level.
// Depends only on the top-level ports.
`default_nettype none

module rfr_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_valid,
    input wire logic        i_ready,
    input wire logic [63:0] o_data_low,
    input wire logic [4:0]  o_byte_count,
    input wire logic [8:0]  o_chunk_length,
    input wire logic        o_chunk_first,
    input wire logic        o_chunk_last,
    input wire logic        o_last_result
);

    // Stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data_low) && $stable(o_byte_count))
        else $error("result changed while stalled");

    // Byte count in range
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_byte_count != 5'd0) && (o_byte_count <= 5'd16))
        else $error("byte count out of range");

    // Single-result chunk carries its whole length
    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_chunk_first && o_chunk_last |-> o_chunk_length == {4'd0, o_byte_count})
        else $error("single-result chunk length mismatch");

    // Final result of a delivery closes its chunk
    a_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last_result |-> o_chunk_last)
        else $error("last result inside a chunk");

    // Reset empties the output
    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

endmodule

bind rtcm_fragment_reassembler rfr_checker u_rfr_checker (.*);

`default_nettype wire
